@@ design/osds_pkg.sv @@
// Shared types and constants of the operand stack unit.
// Used by the interfaces, controller, datapath, top level and checker.
package osds_pkg;

  // Fixed field widths of the item and result channels
  localparam int unsigned OSDS_ACT_W    = 3;
  localparam int unsigned OSDS_WORD_W   = 64;
  localparam int unsigned OSDS_STATUS_W = 2;
  localparam int unsigned OSDS_FILL_W   = 7;

  // Default stack depth
  localparam int unsigned OSDS_DEPTH_DEF = 64;

  typedef enum logic [OSDS_ACT_W-1:0] {
    ACT_PUSH = 3'd0,
    ACT_PEEK = 3'd1,
    ACT_DUP  = 3'd2,
    ACT_SWAP = 3'd3,
    ACT_DUMP = 3'd4
  } osds_act_t;

  typedef enum logic [OSDS_STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } osds_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SWAP,
    S_WR2,
    S_DUMP
  } osds_state_t;

  // Micro-operations the controller issues to the datapath
  typedef enum logic [3:0] {
    UOP_NONE,
    UOP_ACCEPT,
    UOP_PUSH,
    UOP_PEEK,
    UOP_DUP,
    UOP_SWAP_A,
    UOP_SWAP_B,
    UOP_WR2,
    UOP_DUMP
  } osds_uop_t;

  typedef struct packed {
    logic      in_ready;
    osds_uop_t uop;
  } osds_cmd_t;

  typedef struct packed {
    logic      in_valid;
    osds_act_t in_act;
    osds_act_t act;
    logic      fill_zero;
    logic      out_free;
    logic      dump_last;
  } osds_stat_t;

endpackage

@@ design/osds_in_if.sv @@
// Item channel of the operand stack unit: valid, ready and the action payload.
// Depends on osds_pkg for the field widths.
interface osds_in_if import osds_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OSDS_ACT_W-1:0]  action;
  logic [OSDS_WORD_W-1:0] push_value;

  modport source (output valid, output action, output push_value, input ready);
  modport sink   (input valid, input action, input push_value, output ready);
endinterface

@@ design/osds_out_if.sv @@
// Result channel of the operand stack unit: valid, ready and the result payload.
// Depends on osds_pkg for the field widths.
interface osds_out_if import osds_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OSDS_WORD_W-1:0]   word;
  logic [OSDS_STATUS_W-1:0] status;
  logic [OSDS_FILL_W-1:0]   fill;
  logic                     last;

  modport source (output valid, output word, output status, output fill, output last,
                  input ready);
  modport sink   (input valid, input word, input status, input fill, input last,
                  output ready);
endinterface

@@ design/osds_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module osds_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read; hold read data when no read is issued
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/osds_ctrl.sv @@
// Controller of the operand stack unit: sequences each action as micro-operations.
// Depends on osds_pkg for the state, command and status types.
module osds_ctrl import osds_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  osds_stat_t stat,
  output osds_cmd_t  cmd
);

  osds_state_t state, state_next;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (stat.in_valid) begin
          case (stat.in_act)
            ACT_PUSH, ACT_PEEK, ACT_DUP, ACT_SWAP: state_next = S_EXEC;
            ACT_DUMP:                              state_next = S_DUMP;
            default:                               state_next = S_IDLE;
          endcase
        end
      end
      S_EXEC: begin
        case (stat.act)
          ACT_PUSH, ACT_PEEK: if (stat.out_free) state_next = S_IDLE;
          ACT_DUP: begin
            if (stat.fill_zero) begin
              state_next = S_WR2;
            end else if (stat.out_free) begin
              state_next = S_IDLE;
            end
          end
          ACT_SWAP: state_next = S_SWAP;
          default:  state_next = S_IDLE;
        endcase
      end
      S_SWAP: state_next = S_WR2;
      S_WR2: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      S_DUMP: begin
        if (stat.out_free && (stat.fill_zero || stat.dump_last)) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Command outputs; hold off transfers while reset is applied
  always_comb begin
    cmd.in_ready = 1'b0;
    cmd.uop      = UOP_NONE;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = !rst;
        if (stat.in_valid && !rst) cmd.uop = UOP_ACCEPT;
      end
      S_EXEC: begin
        case (stat.act)
          ACT_PUSH: if (stat.out_free) cmd.uop = UOP_PUSH;
          ACT_PEEK: if (stat.out_free) cmd.uop = UOP_PEEK;
          ACT_DUP:  if (stat.fill_zero || stat.out_free) cmd.uop = UOP_DUP;
          ACT_SWAP: cmd.uop = UOP_SWAP_A;
          default:  cmd.uop = UOP_NONE;
        endcase
      end
      S_SWAP: cmd.uop = UOP_SWAP_B;
      S_WR2:  if (stat.out_free) cmd.uop = UOP_WR2;
      S_DUMP: if (stat.out_free) cmd.uop = UOP_DUMP;
      default: cmd.uop = UOP_NONE;
    endcase
  end

endmodule

@@ design/osds_dpath.sv @@
// Datapath of the operand stack unit: fill count, stack memory, holding and output registers.
// Depends on osds_pkg, osds_in_if, osds_out_if and osds_ram.
module osds_dpath import osds_pkg::*; #(
  parameter int unsigned STACK_DEPTH = OSDS_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  osds_cmd_t         cmd,
  output osds_stat_t        stat,
  osds_in_if.sink           item,
  osds_out_if.source        result
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned FW = $clog2(STACK_DEPTH + 1);

  logic [FW-1:0]          fill, fill_next;
  osds_act_t              act;
  logic [OSDS_WORD_W-1:0] value;
  logic [OSDS_WORD_W-1:0] hold, hold_next;
  osds_status_t           st_hold, st_next;
  logic [AW-1:0]          idx, idx_next;

  logic                   out_valid;
  logic [OSDS_WORD_W-1:0] out_word;
  osds_status_t           out_status;
  logic [FW-1:0]          out_fill;
  logic                   out_last;

  logic                   rd_en, wr_en;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic [OSDS_WORD_W-1:0] rd_data, wr_data;

  logic                   load;
  logic [OSDS_WORD_W-1:0] ld_word;
  osds_status_t           ld_status;
  logic                   ld_last;

  logic                   fill_zero, fill_lt2, fill_full, dump_last, out_free;
  logic [FW-1:0]          fill_m1, fill_m2, swap_base;

  // Stack storage
  osds_ram #(
    .WIDTH (OSDS_WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Fill flags and derived addresses
  assign fill_zero = (fill == '0);
  assign fill_lt2  = (fill < FW'(2));
  assign fill_full = (fill == FW'(STACK_DEPTH));
  assign fill_m1   = fill - FW'(1);
  assign fill_m2   = fill - FW'(2);
  assign swap_base = fill_lt2 ? '0 : fill_m2;
  assign dump_last = ((FW'(idx) + FW'(1)) == fill);
  assign out_free  = !out_valid || result.ready;

  // Status to the controller
  assign stat.in_valid  = item.valid;
  assign stat.in_act    = osds_act_t'(item.action);
  assign stat.act       = act;
  assign stat.fill_zero = fill_zero;
  assign stat.out_free  = out_free;
  assign stat.dump_last = dump_last;

  assign item.ready = cmd.in_ready;

  // Decode micro-operations
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = fill_m1[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = fill[AW-1:0];
    wr_data   = value;
    fill_next = fill;
    hold_next = hold;
    st_next   = st_hold;
    idx_next  = idx;
    load      = 1'b0;
    ld_word   = '0;
    ld_status = ST_OK;
    ld_last   = 1'b1;
    unique case (cmd.uop)
      UOP_NONE: begin
      end
      UOP_ACCEPT: begin
        rd_en    = 1'b1;
        rd_addr  = (osds_act_t'(item.action) == ACT_DUMP) ? '0 : fill_m1[AW-1:0];
        idx_next = '0;
      end
      UOP_PUSH: begin
        load = 1'b1;
        if (fill_full) begin
          ld_status = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          fill_next = fill + FW'(1);
        end
      end
      UOP_PEEK: begin
        load = 1'b1;
        if (fill_zero) begin
          ld_status = ST_EMPTY;
        end else begin
          ld_word = rd_data;
        end
      end
      UOP_DUP: begin
        if (fill_zero) begin
          // Empty pop gives zero: write the first zero, the second follows
          wr_en     = 1'b1;
          wr_addr   = '0;
          wr_data   = '0;
          fill_next = FW'(1);
          hold_next = '0;
          st_next   = ST_EMPTY;
        end else begin
          load = 1'b1;
          if (fill_full) begin
            ld_status = ST_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_data   = rd_data;
            fill_next = fill + FW'(1);
          end
        end
      end
      UOP_SWAP_A: begin
        // Keep the popped top, read the one below
        hold_next = fill_zero ? '0 : rd_data;
        rd_en     = 1'b1;
        rd_addr   = fill_m2[AW-1:0];
        st_next   = fill_lt2 ? ST_EMPTY : ST_OK;
      end
      UOP_SWAP_B: begin
        // Write the old top lower down, keep the old second for the upper slot
        wr_en     = 1'b1;
        wr_addr   = swap_base[AW-1:0];
        wr_data   = hold;
        fill_next = swap_base + FW'(1);
        hold_next = fill_lt2 ? '0 : rd_data;
      end
      UOP_WR2: begin
        wr_en     = 1'b1;
        wr_data   = hold;
        fill_next = fill + FW'(1);
        load      = 1'b1;
        ld_status = st_hold;
      end
      UOP_DUMP: begin
        load = 1'b1;
        if (fill_zero) begin
          ld_status = ST_EMPTY;
        end else begin
          ld_word = rd_data;
          ld_last = dump_last;
          if (!dump_last) begin
            idx_next = idx + AW'(1);
            rd_en    = 1'b1;
            rd_addr  = idx + AW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      fill <= fill_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.uop == UOP_ACCEPT) begin
      act   <= osds_act_t'(item.action);
      value <= item.push_value;
    end
    hold    <= hold_next;
    st_hold <= st_next;
    idx     <= idx_next;
    if (load) begin
      out_word   <= ld_word;
      out_status <= ld_status;
      out_fill   <= fill_next;
      out_last   <= ld_last;
    end
  end

  // Drive the result channel
  assign result.valid  = out_valid;
  assign result.word   = out_word;
  assign result.status = out_status;
  assign result.fill   = OSDS_FILL_W'(out_fill);
  assign result.last   = out_last;

endmodule

@@ design/operand_stack_dup_swap_unit.sv @@
// Top level of the operand stack unit: controller plus datapath.
// Depends on osds_pkg, osds_in_if, osds_out_if, osds_ctrl and osds_dpath.
//
// A LIFO stack of 64-bit words, STACK_DEPTH entries deep, driven one item at a time. Push,
// peek and duplicate transfer the item and issue the stack read, then use the registered
// read data to load the result; duplicate on an empty stack writes its two zeros in turn,
// since they go through the single write port; swap reads the top, then the entry below it,
// then writes them back in turn, since the memory has one read and one write port; dump
// streams the entries bottom to top through the read port, one result per entry, and gives
// one result on an empty stack. Undefined action codes are taken and give no result. No
// item is taken while reset is applied. The result sits in an output register, so the next
// item is taken while a result waits; a stalled result channel stalls only the point at
// which the next result is loaded. The stack memory needs no clearing pass after reset: only
// entries below the fill count are ever used.
module operand_stack_dup_swap_unit import osds_pkg::*; #(
  parameter int unsigned STACK_DEPTH = OSDS_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  osds_in_if.sink     item,
  osds_out_if.source  result
);

  osds_cmd_t  cmd;
  osds_stat_t stat;

  osds_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  osds_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .stat   (stat),
    .item   (item),
    .result (result)
  );

endmodule

@@ design/osds_checker.sv @@
// Port-level checker of the operand stack unit, bound to the top level.
// Depends on osds_pkg for the field widths and status codes.
module osds_checker import osds_pkg::*; #(
  parameter int unsigned STACK_DEPTH = OSDS_DEPTH_DEF
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [OSDS_WORD_W-1:0]   out_word,
  input logic [OSDS_STATUS_W-1:0] out_status,
  input logic [OSDS_FILL_W-1:0]   out_fill,
  input logic                     out_last
);

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_status)
      && $stable(out_fill) && $stable(out_last))
    else $error("stalled result changed");

  // Full status only with a full stack
  a_full_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_FULL |-> out_fill == OSDS_FILL_W'(STACK_DEPTH))
    else $error("full status with stack not full");

  // Underflow ends the item and leaves an empty stack or two entries
  a_empty_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_EMPTY |-> out_last
      && (out_fill == OSDS_FILL_W'(0) || out_fill == OSDS_FILL_W'(2)))
    else $error("bad fill or last on underflow");

  // Only a dump gives non-final results, all ok from a non-empty stack
  a_dump_body: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> out_status == ST_OK && out_fill != OSDS_FILL_W'(0))
    else $error("bad non-final result");

  // Fill never exceeds the depth
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_fill <= OSDS_FILL_W'(STACK_DEPTH))
    else $error("fill beyond depth");

endmodule

bind operand_stack_dup_swap_unit osds_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_osds_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_word   (result.word),
  .out_status (result.status),
  .out_fill   (result.fill),
  .out_last   (result.last)
);
